FILE: hw/rtl/cpg_pkg.sv
// shared constants, codes and types of the pattern generator channel
package cpg_pkg;

    localparam int SINE_TABLE_DEPTH = 1024;
    localparam int SINE_IDX_W       = $clog2(SINE_TABLE_DEPTH);
    localparam int SINE_DROP        = 32 - SINE_IDX_W;
    localparam logic [31:0] SINE_MASK = ~((32'h1 << SINE_DROP) - 32'h1);

    localparam int TGT_W      = 24;
    localparam int OMEGA_W    = 24;
    localparam int RATIO_W    = 16;
    localparam int OUT_W      = 24;
    localparam int STATE_W    = 56;
    localparam int PHASE_W    = 32;
    localparam int GAIN_W     = 8;
    localparam int TSTEP_W    = 32;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    localparam int MUL_A_W   = 58;
    localparam int MAG_W     = MUL_A_W - 1;
    localparam int MUL_B_W   = 48;
    localparam int MUL_CNT_W = $clog2(MUL_B_W + 1);
    localparam int MUL_P_W   = MAG_W + 1 + MUL_B_W;

    localparam int DIV_N_W   = 35;
    localparam int DIV_D_W   = 16;
    localparam int DIV_CNT_W = $clog2(DIV_N_W + 1);

    localparam logic [GAIN_W-1:0]  GAIN_RST      = 8'd5;
    localparam logic [TSTEP_W-1:0] TIME_STEP_RST = 32'd4294967;
    localparam logic [RATIO_W-1:0] RATIO_MIN     = 16'd1024;
    localparam logic [16:0]        RATIO_BIAS    = 17'd4096;
    localparam logic [31:0]        R_SQ_ONE      = 32'h0100_0000;
    localparam logic [31:0]        QUARTER_TURN  = 32'h4000_0000;
    localparam logic [30:0]        Q30_ONE       = 31'h4000_0000;
    localparam logic [29:0]        INV_TWO_PI    = 30'd683565276;
    localparam logic [31:0]        SIN_A1        = 32'd1686629713;
    localparam logic [31:0]        SIN_A3        = 32'd693598668;
    localparam logic [31:0]        SIN_A5        = 32'd85569306;
    localparam logic [31:0]        SIN_A7        = 32'd5026995;
    localparam logic [31:0]        SIN_A9        = 32'd172272;

    localparam logic signed [STATE_W-1:0] LIM_POS = {1'b0, {(STATE_W-1){1'b1}}};
    localparam logic signed [STATE_W-1:0] LIM_NEG = {1'b1, {(STATE_W-1){1'b0}}};

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_BIAS_GAIN = 2'd0,
        REG_AMP_GAIN  = 2'd1,
        REG_TIME_STEP = 2'd2
    } cfg_reg_t;

    typedef enum logic [1:0] {
        SH_0,
        SH_2,
        SH_30,
        SH_32
    } shift_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_ISSUE,
        S_WAIT
    } fsm_t;

    typedef enum logic [4:0] {
        ST_KK, ST_KM, ST_TT, ST_C2B, ST_C2M, ST_C1, ST_TW,
        ST_SU2, ST_SP9, ST_SP7, ST_SP5, ST_SP3, ST_SP1,
        ST_SWING, ST_SQ, ST_K1, ST_RR, ST_K2, ST_KS, ST_X, ST_DPH,
        ST_T1B, ST_T2B, ST_T1M, ST_T2M
    } step_t;

    typedef struct packed {
        logic                       start;
        logic signed [MUL_A_W-1:0]  a;
        logic [MUL_B_W-1:0]         b;
        shift_t                     sh;
    } mul_req_t;

    typedef struct packed {
        logic                       busy;
        logic signed [STATE_W-1:0]  res;
    } mul_rsp_t;

    typedef struct packed {
        logic               start;
        logic [DIV_N_W-1:0] num;
        logic [DIV_D_W-1:0] den;
    } div_req_t;

    typedef struct packed {
        logic               busy;
        logic [DIV_N_W-1:0] quo;
    } div_rsp_t;

endpackage

FILE: hw/rtl/cpg_if.sv
// tick and result channel interfaces
interface cpg_in_if;
    logic               valid;
    logic               ready;
    logic signed [23:0] bias_target;
    logic signed [23:0] amplitude_target;
    logic [23:0]        angular_rate;
    logic [15:0]        swing_ratio;

    modport source (output valid, bias_target, amplitude_target, angular_rate, swing_ratio,
                    input ready);
    modport sink   (input valid, bias_target, amplitude_target, angular_rate, swing_ratio,
                    output ready);
endinterface

interface cpg_out_if;
    logic               valid;
    logic               ready;
    logic signed [23:0] drive_value;
    logic signed [23:0] mirror_value;

    modport source (output valid, drive_value, mirror_value, input ready);
    modport sink   (input valid, drive_value, mirror_value, output ready);
endinterface

FILE: hw/rtl/cpg_serial_mul.sv
// bit-serial signed by unsigned multiplier with floor shift and 56-bit saturation
module cpg_serial_mul
    import cpg_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  mul_req_t req,
    output mul_rsp_t rsp
);

    logic                      busy_reg, busy_next;
    logic [MUL_CNT_W-1:0]      cnt_reg, cnt_next;
    logic                      neg_reg;
    logic [MAG_W-1:0]          mag_reg;
    logic [MUL_P_W-1:0]        prod_reg;
    shift_t                    sh_reg;
    logic signed [STATE_W-1:0] res_reg;
    logic [MAG_W:0]            hi_sum;
    logic [MUL_P_W-1:0]        quo;
    logic [MUL_P_W-1:0]        quo_up;
    logic                      rem;
    logic signed [STATE_W-1:0] res_next;

    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = MUL_CNT_W'(MUL_B_W);
        end
        else if (busy_reg)
        begin
            if (cnt_reg != '0)
                cnt_next = cnt_reg - 1'b1;
            else
                busy_next = 1'b0;
        end
    end

    // one multiplier bit per cycle, partial sum shifts right
    assign hi_sum = {1'b0, prod_reg[MUL_P_W-2:MUL_B_W]}
                  + {1'b0, (prod_reg[0] ? mag_reg : MAG_W'(0))};

    always_comb
    begin
        case (sh_reg)
            SH_0:
            begin
                quo = prod_reg;
                rem = 1'b0;
            end
            SH_2:
            begin
                quo = prod_reg >> 2;
                rem = |prod_reg[1:0];
            end
            SH_30:
            begin
                quo = prod_reg >> 30;
                rem = |prod_reg[29:0];
            end
            default:
            begin
                quo = prod_reg >> 32;
                rem = |prod_reg[31:0];
            end
        endcase
        quo_up = quo + MUL_P_W'(rem);
        if (!neg_reg)
        begin
            if (|quo[MUL_P_W-1:STATE_W-1])
                res_next = LIM_POS;
            else
                res_next = quo[STATE_W-1:0];
        end
        else
        begin
            if ((|quo_up[MUL_P_W-1:STATE_W]) ||
                (quo_up[STATE_W-1] && (|quo_up[STATE_W-2:0])))
                res_next = LIM_NEG;
            else
                res_next = -$signed(quo_up[STATE_W-1:0]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            neg_reg  <= req.a[MUL_A_W-1];
            mag_reg  <= req.a[MUL_A_W-1] ? MAG_W'(-req.a) : req.a[MAG_W-1:0];
            prod_reg <= MUL_P_W'(req.b);
            sh_reg   <= req.sh;
        end
        else if (busy_reg && (cnt_reg != '0))
        begin
            prod_reg <= {1'b0, hi_sum, prod_reg[MUL_B_W-1:1]};
        end
        else if (busy_reg)
        begin
            res_reg <= res_next;
        end
    end

    assign rsp.busy = busy_reg;
    assign rsp.res  = res_reg;

endmodule

FILE: hw/rtl/cpg_serial_div.sv
// restoring divider, one quotient bit per cycle
module cpg_serial_div
    import cpg_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  div_req_t req,
    output div_rsp_t rsp
);

    logic                 busy_reg, busy_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [DIV_D_W-1:0]   den_reg;
    logic [DIV_D_W-1:0]   rem_reg;
    logic [DIV_N_W-1:0]   quo_reg;
    logic [DIV_D_W:0]     rem_sh;
    logic                 fits;

    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = DIV_CNT_W'(DIV_N_W);
        end
        else if (busy_reg)
        begin
            if (cnt_reg != '0)
                cnt_next = cnt_reg - 1'b1;
            else
                busy_next = 1'b0;
        end
    end

    assign rem_sh = {rem_reg, quo_reg[DIV_N_W-1]};
    assign fits   = rem_sh >= {1'b0, den_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            den_reg <= req.den;
            rem_reg <= '0;
            quo_reg <= req.num;
        end
        else if (busy_reg && (cnt_reg != '0))
        begin
            rem_reg <= fits ? DIV_D_W'(rem_sh - {1'b0, den_reg}) : rem_sh[DIV_D_W-1:0];
            quo_reg <= {quo_reg[DIV_N_W-2:0], fits};
        end
    end

    assign rsp.busy = busy_reg;
    assign rsp.quo  = quo_reg;

endmodule

FILE: hw/rtl/cpg_oscillator_step.sv
// top level: one pattern generator channel, stepped once per tick
//
// tick (valid/ready) carries the targets, angular rate and swing ratio of one
// step; result (valid/ready) returns drive_value and mirror_value, formed from
// the older stored bias and amplitude and the phase as it stood before the step.
// Configuration is a write-only port (wr_en, wr_index, wr_data), to be written
// while the block is idle (the block itself does not enforce this); an unknown
// index is ignored. A sequencer walks 31 arithmetic steps (the sine steps run
// twice, once for cosine and once for sine) through one shared bit-serial
// multiplier and one serial divider. The result is registered at the swing
// step, and tick.ready returns once the last step has been written back.
// The result sits in an output register: a stalled receiver does not hold up
// the rest of the step, and only stalls the next step when its result is ready
// while the previous one is still waiting.
// Reset clears bias, amplitude and phase, loads default gains and time step,
// and leaves the block ready for a tick.
module cpg_oscillator_step
    import cpg_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    cpg_in_if.sink                tick,
    cpg_out_if.source             result,
    input  logic                  wr_en,
    input  logic [CFG_IDX_W-1:0]  wr_index,
    input  logic [CFG_DATA_W-1:0] wr_data
);

    function automatic logic signed [STATE_W-1:0] sat56(input logic signed [STATE_W+2:0] v);
        logic signed [STATE_W-1:0] r;
        if ((v[STATE_W+2:STATE_W-1] == '0) || (v[STATE_W+2:STATE_W-1] == '1))
            r = v[STATE_W-1:0];
        else
            r = v[STATE_W+2] ? LIM_NEG : LIM_POS;
        return r;
    endfunction

    function automatic logic signed [OUT_W-1:0] to_out(input logic signed [STATE_W:0] v);
        logic signed [STATE_W-24:0] y;
        logic signed [OUT_W-1:0]    r;
        y = v[STATE_W:24];
        if ((y[STATE_W-24:OUT_W-1] == '0) || (y[STATE_W-24:OUT_W-1] == '1))
            r = y[OUT_W-1:0];
        else
            r = y[STATE_W-24] ? {1'b1, {(OUT_W-1){1'b0}}} : {1'b0, {(OUT_W-1){1'b1}}};
        return r;
    endfunction

    fsm_t  state_reg, state_next;
    step_t step_reg, step_next;
    logic  pass_reg, pass_next;

    logic [GAIN_W-1:0]  kb_reg, km_reg;
    logic [TSTEP_W-1:0] ts_reg;

    logic signed [TGT_W-1:0] btgt_reg, mtgt_reg;
    logic [OMEGA_W-1:0]      omega_reg;
    logic [RATIO_W-1:0]      ratio_reg;

    logic [15:0]        kk_reg, kbm_reg;
    logic [31:0]        tt_reg;
    logic [45:0]        c2b_reg, c2m_reg;
    logic [39:0]        c1_reg;
    logic [23:0]        tw_reg;
    logic [30:0]        u2_reg;
    logic [31:0]        poly_reg;
    logic signed [31:0] cos_reg, sin_reg;
    logic [32:0]        sq_reg;
    logic [24:0]        k1_reg;
    logic [31:0]        rr_reg;
    logic signed [18:0] k2_reg;
    logic signed [26:0] rate_reg;
    logic signed [STATE_W-1:0] x_reg, t1_reg, nb_reg;
    logic [PHASE_W-1:0] dph_reg;

    logic signed [STATE_W-1:0] bias_old_reg, bias_new_reg, amp_old_reg, amp_new_reg;
    logic [PHASE_W-1:0]        phase_reg;

    logic                    out_valid_reg;
    logic signed [OUT_W-1:0] drive_reg, mirror_reg;

    mul_req_t mul_req;
    mul_rsp_t mul_rsp;
    div_req_t div_req;
    div_rsp_t div_rsp;

    logic        accept, is_div, unit_busy, out_ok, wb;
    logic [31:0] ang, tq;
    logic [30:0] u_low, u;
    logic [31:0] sq_diff;
    logic        rr_lt;
    logic [30:0] p_clamp;
    logic signed [31:0] s_val;
    logic signed [STATE_W-1:0] res;
    logic signed [STATE_W:0]   swing_sum, swing_diff;

    cpg_serial_mul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (mul_req),
        .rsp   (mul_rsp)
    );

    cpg_serial_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    assign accept    = (state_reg == S_IDLE) && tick.valid;
    assign is_div    = (step_reg == ST_K1) || (step_reg == ST_K2);
    assign unit_busy = is_div ? div_rsp.busy : mul_rsp.busy;
    // the output step waits for a free result slot
    assign out_ok    = (step_reg != ST_SWING) || !out_valid_reg || result.ready;
    assign wb        = (state_reg == S_WAIT) && !unit_busy && out_ok;
    assign res       = mul_rsp.res;

    // sine sample position: quantize the angle, fold into the quarter wave
    assign ang   = pass_reg ? phase_reg : phase_reg + QUARTER_TURN;
    assign tq    = ang & SINE_MASK;
    assign u_low = {1'b0, tq[29:0]};
    assign u     = tq[30] ? Q30_ONE - u_low : u_low;

    assign rr_lt   = rr_reg < R_SQ_ONE;
    assign sq_diff = rr_lt ? R_SQ_ONE - rr_reg : rr_reg - R_SQ_ONE;

    assign p_clamp = (res[31:0] > {1'b0, Q30_ONE}) ? Q30_ONE : res[30:0];
    assign s_val   = tq[31] ? -$signed({1'b0, p_clamp}) : $signed({1'b0, p_clamp});

    assign swing_sum  = $signed({bias_old_reg[STATE_W-1], bias_old_reg})
                      + $signed({res[STATE_W-1], res});
    assign swing_diff = $signed({bias_old_reg[STATE_W-1], bias_old_reg})
                      - $signed({res[STATE_W-1], res});

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
                if (tick.valid)
                    state_next = S_ISSUE;
            S_ISSUE:
                state_next = S_WAIT;
            S_WAIT:
                if (wb)
                    state_next = (step_reg == ST_T2M) ? S_IDLE : S_ISSUE;
            default:
                state_next = S_IDLE;
        endcase
    end

    // step sequence
    always_comb
    begin
        step_next = step_reg;
        pass_next = pass_reg;
        if (accept)
        begin
            step_next = ST_KK;
            pass_next = 1'b0;
        end
        else if (wb && (step_reg != ST_T2M))
        begin
            if ((step_reg == ST_SP1) && !pass_reg)
            begin
                step_next = ST_SU2;
                pass_next = 1'b1;
            end
            else
            begin
                step_next = step_t'(step_reg + 5'd1);
            end
        end
    end

    // unit operands and starts
    always_comb
    begin
        mul_req.start = (state_reg == S_ISSUE) && !is_div;
        mul_req.a     = '0;
        mul_req.b     = '0;
        mul_req.sh    = SH_0;
        div_req.start = (state_reg == S_ISSUE) && is_div;
        div_req.num   = '0;
        div_req.den   = ratio_reg;
        case (step_reg)
            ST_KK:
            begin
                mul_req.a = MUL_A_W'(kb_reg);
                mul_req.b = MUL_B_W'(kb_reg);
            end
            ST_KM:
            begin
                mul_req.a = MUL_A_W'(kb_reg);
                mul_req.b = MUL_B_W'(km_reg);
            end
            ST_TT:
            begin
                mul_req.a  = MUL_A_W'(ts_reg);
                mul_req.b  = MUL_B_W'(ts_reg);
                mul_req.sh = SH_32;
            end
            ST_C2B:
            begin
                mul_req.a  = MUL_A_W'(tt_reg);
                mul_req.b  = MUL_B_W'(kk_reg);
                mul_req.sh = SH_2;
            end
            ST_C2M:
            begin
                mul_req.a  = MUL_A_W'(tt_reg);
                mul_req.b  = MUL_B_W'(kbm_reg);
                mul_req.sh = SH_2;
            end
            ST_C1:
            begin
                mul_req.a = MUL_A_W'(ts_reg);
                mul_req.b = MUL_B_W'(kb_reg);
            end
            ST_TW:
            begin
                mul_req.a  = MUL_A_W'(ts_reg);
                mul_req.b  = MUL_B_W'(omega_reg);
                mul_req.sh = SH_32;
            end
            ST_SU2:
            begin
                mul_req.a  = MUL_A_W'(u);
                mul_req.b  = MUL_B_W'(u);
                mul_req.sh = SH_30;
            end
            ST_SP9:
            begin
                mul_req.a  = MUL_A_W'(u2_reg);
                mul_req.b  = MUL_B_W'(SIN_A9);
                mul_req.sh = SH_30;
            end
            ST_SP7, ST_SP5, ST_SP3:
            begin
                mul_req.a  = MUL_A_W'(u2_reg);
                mul_req.b  = MUL_B_W'(poly_reg);
                mul_req.sh = SH_30;
            end
            ST_SP1:
            begin
                mul_req.a  = MUL_A_W'(u);
                mul_req.b  = MUL_B_W'(poly_reg);
                mul_req.sh = SH_30;
            end
            ST_SWING:
            begin
                mul_req.a  = cos_reg[31] ? -MUL_A_W'(amp_old_reg) : MUL_A_W'(amp_old_reg);
                mul_req.b  = cos_reg[31] ? MUL_B_W'(-cos_reg) : MUL_B_W'(cos_reg);
                mul_req.sh = SH_30;
            end
            ST_SQ:
            begin
                mul_req.a = MUL_A_W'({1'b0, ratio_reg} + RATIO_BIAS);
                mul_req.b = MUL_B_W'({1'b0, ratio_reg} + RATIO_BIAS);
            end
            ST_K1:
                div_req.num = {sq_reg, 2'b00};
            ST_RR:
            begin
                mul_req.a = MUL_A_W'(ratio_reg);
                mul_req.b = MUL_B_W'(ratio_reg);
            end
            ST_K2:
                div_req.num = DIV_N_W'({sq_diff, 2'b00});
            ST_KS:
            begin
                mul_req.a  = sin_reg[31] ? -MUL_A_W'(k2_reg) : MUL_A_W'(k2_reg);
                mul_req.b  = sin_reg[31] ? MUL_B_W'(-sin_reg) : MUL_B_W'(sin_reg);
                mul_req.sh = SH_30;
            end
            ST_X:
            begin
                mul_req.a = MUL_A_W'(rate_reg);
                mul_req.b = MUL_B_W'(tw_reg);
            end
            ST_DPH:
            begin
                mul_req.a  = MUL_A_W'(x_reg);
                mul_req.b  = MUL_B_W'(INV_TWO_PI);
                mul_req.sh = SH_32;
            end
            ST_T1B:
            begin
                mul_req.a  = MUL_A_W'($signed({btgt_reg, 24'h0})) - MUL_A_W'(bias_old_reg);
                mul_req.b  = MUL_B_W'(c2b_reg);
                mul_req.sh = SH_32;
            end
            ST_T2B:
            begin
                mul_req.a  = MUL_A_W'(bias_new_reg) - MUL_A_W'(bias_old_reg);
                mul_req.b  = MUL_B_W'(c1_reg);
                mul_req.sh = SH_32;
            end
            ST_T1M:
            begin
                mul_req.a  = MUL_A_W'($signed({mtgt_reg, 24'h0})) - MUL_A_W'(amp_old_reg);
                mul_req.b  = MUL_B_W'(c2m_reg);
                mul_req.sh = SH_32;
            end
            ST_T2M:
            begin
                mul_req.a  = MUL_A_W'(amp_new_reg) - MUL_A_W'(amp_old_reg);
                mul_req.b  = MUL_B_W'(c1_reg);
                mul_req.sh = SH_32;
            end
            default:
            begin
                mul_req.a = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            step_reg  <= ST_KK;
            pass_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
            pass_reg  <= pass_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kb_reg <= GAIN_RST;
            km_reg <= GAIN_RST;
            ts_reg <= TIME_STEP_RST;
        end
        else if (wr_en)
        begin
            case (wr_index)
                REG_BIAS_GAIN: kb_reg <= wr_data[GAIN_W-1:0];
                REG_AMP_GAIN:  km_reg <= wr_data[GAIN_W-1:0];
                REG_TIME_STEP: ts_reg <= wr_data[TSTEP_W-1:0];
                default:       ts_reg <= ts_reg;
            endcase
        end
    end

    // oscillator state and result slot
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bias_old_reg  <= '0;
            bias_new_reg  <= '0;
            amp_old_reg   <= '0;
            amp_new_reg   <= '0;
            phase_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (wb && (step_reg == ST_SWING))
                out_valid_reg <= 1'b1;
            else if (result.ready)
                out_valid_reg <= 1'b0;
            if (wb && (step_reg == ST_T2M))
            begin
                bias_old_reg <= bias_new_reg;
                bias_new_reg <= nb_reg;
                amp_old_reg  <= amp_new_reg;
                amp_new_reg  <= sat56((STATE_W+3)'(t1_reg) - (STATE_W+3)'(res)
                                      + ((STATE_W+3)'(amp_new_reg) <<< 1)
                                      - (STATE_W+3)'(amp_old_reg));
                phase_reg    <= phase_reg + dph_reg;
            end
        end
    end

    // operands of the tick and intermediate results
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            btgt_reg  <= tick.bias_target;
            mtgt_reg  <= tick.amplitude_target;
            omega_reg <= tick.angular_rate;
            ratio_reg <= (tick.swing_ratio < RATIO_MIN) ? RATIO_MIN : tick.swing_ratio;
        end
        if (wb)
        begin
            case (step_reg)
                ST_KK:  kk_reg   <= res[15:0];
                ST_KM:  kbm_reg  <= res[15:0];
                ST_TT:  tt_reg   <= res[31:0];
                ST_C2B: c2b_reg  <= res[45:0];
                ST_C2M: c2m_reg  <= res[45:0];
                ST_C1:  c1_reg   <= res[39:0];
                ST_TW:  tw_reg   <= res[23:0];
                ST_SU2: u2_reg   <= res[30:0];
                ST_SP9: poly_reg <= SIN_A7 - res[31:0];
                ST_SP7: poly_reg <= SIN_A5 - res[31:0];
                ST_SP5: poly_reg <= SIN_A3 - res[31:0];
                ST_SP3: poly_reg <= SIN_A1 - res[31:0];
                ST_SP1:
                begin
                    if (pass_reg)
                        sin_reg <= s_val;
                    else
                        cos_reg <= s_val;
                end
                ST_SWING:
                begin
                    drive_reg  <= to_out(swing_sum);
                    mirror_reg <= to_out(swing_diff);
                end
                ST_SQ:  sq_reg <= res[32:0];
                ST_K1:  k1_reg <= div_rsp.quo[24:0];
                ST_RR:  rr_reg <= res[31:0];
                ST_K2:  k2_reg <= rr_lt ? -$signed({1'b0, div_rsp.quo[17:0]})
                                        : $signed({1'b0, div_rsp.quo[17:0]});
                ST_KS:  rate_reg <= $signed({2'b00, k1_reg}) - 27'(res);
                ST_X:   x_reg    <= res;
                ST_DPH: dph_reg  <= res[PHASE_W-1:0];
                ST_T1B: t1_reg   <= res;
                ST_T2B: nb_reg   <= sat56((STATE_W+3)'(t1_reg) - (STATE_W+3)'(res)
                                          + ((STATE_W+3)'(bias_new_reg) <<< 1)
                                          - (STATE_W+3)'(bias_old_reg));
                ST_T1M: t1_reg   <= res;
                default: dph_reg <= dph_reg;
            endcase
        end
    end

    assign tick.ready          = (state_reg == S_IDLE);
    assign result.valid        = out_valid_reg;
    assign result.drive_value  = drive_reg;
    assign result.mirror_value = mirror_reg;

endmodule

FILE: hw/rtl/cpg_checker.sv
// port-level checks of the pattern generator channel, bound to the top level
module cpg_checker
    import cpg_pkg::*;
(
    input logic             clk,
    input logic             rst_n,
    input logic             in_valid,
    input logic             in_ready,
    input logic             out_valid,
    input logic             out_ready,
    input logic [OUT_W-1:0] drive_value,
    input logic [OUT_W-1:0] mirror_value
);

    // a stalled result keeps its values
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(drive_value) && $stable(mirror_value))
        else $error("result changed while stalled");

    // one step at a time
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("tick taken while a step is running");

    // a result only appears in the middle of a step
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> !in_ready)
        else $error("result appeared while idle");

    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !$rose(out_valid))
        else $error("result appeared right after a tick transfer");

endmodule

bind cpg_oscillator_step cpg_checker u_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (tick.valid),
    .in_ready     (tick.ready),
    .out_valid    (result.valid),
    .out_ready    (result.ready),
    .drive_value  (result.drive_value),
    .mirror_value (result.mirror_value)
);

FILE: sim/cpg_tb_if.sv
// no extra interfaces: the channel interfaces come from the rtl tree
`timescale 1ns / 1ps

FILE: sim/tb_cpg_oscillator_step.sv
// testbench of cpg_oscillator_step: directed and random ticks checked against a bit-exact predictor
`timescale 1ns / 1ps
module tb_cpg_oscillator_step;
    import cpg_pkg::*;

    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
    localparam int CYCLE_LIMIT = 12000000;
    localparam int DRAIN_CYCLES = 2500;
    localparam logic signed [63:0] SAT_POS = 64'sd36028797018963967;
    localparam logic signed [63:0] SAT_NEG = -64'sd36028797018963968;

    typedef struct packed {
        logic signed [23:0] bias_tgt;
        logic signed [23:0] amp_tgt;
        logic [23:0]        omega;
        logic [15:0]        ratio;
    } tick_t;

    typedef struct packed {
        logic signed [23:0] drive;
        logic signed [23:0] mirror;
    } pair_t;

    logic clk;
    logic rst_n;
    logic wr_en;
    logic [CFG_IDX_W-1:0] wr_index;
    logic [CFG_DATA_W-1:0] wr_data;

    cpg_in_if  tick_ch();
    cpg_out_if res_ch();

    cpg_oscillator_step dut (
        .clk(clk), .rst_n(rst_n), .tick(tick_ch.sink), .result(res_ch.source),
        .wr_en(wr_en), .wr_index(wr_index), .wr_data(wr_data)
    );

    tick_t pending_ticks[$];
    pair_t expected_pairs[$];
    int mismatches = 0;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    bit pressure_arm = 0;
    int cycles = 0;

    // predictor state
    logic [63:0] kb = 64'd5, km = 64'd5, tstep = 64'd4294967;
    logic signed [63:0] b_old = 0, b_new = 0, m_old = 0, m_new = 0;
    logic [31:0] phase = 0;

    function automatic logic signed [63:0] clamp56(logic signed [129:0] v);
        if (v > SAT_POS) return SAT_POS;
        if (v < SAT_NEG) return SAT_NEG;
        return v[63:0];
    endfunction

    // floor(a*b / 2^sh), clamped to 56 bits
    function automatic logic signed [63:0] scale_mul(logic signed [63:0] a, logic [63:0] b,
                                                     int sh);
        logic signed [129:0] aa, bb, p;
        aa = a;
        bb = $signed({66'd0, b});
        p = (aa * bb) >>> sh;
        return clamp56(p);
    endfunction

    function automatic logic signed [63:0] sine_of(logic [31:0] ang);
        logic [31:0] t;
        logic [63:0] u, u2, p;
        t = {ang[31:22], 22'd0};
        u = {34'd0, t[29:0]};
        if (t[30]) u = 64'h4000_0000 - u;
        u2 = (u * u) >> 30;
        p = SIN_A9;
        p = SIN_A7 - ((u2 * p) >> 30);
        p = SIN_A5 - ((u2 * p) >> 30);
        p = SIN_A3 - ((u2 * p) >> 30);
        p = SIN_A1 - ((u2 * p) >> 30);
        p = (u * p) >> 30;
        if (p > 64'h4000_0000) p = 64'h4000_0000;
        return t[31] ? -$signed(p) : $signed(p);
    endfunction

    function automatic logic signed [23:0] to_q16_8(logic signed [63:0] v);
        logic signed [63:0] y;
        y = v >>> 24;
        if (y > 64'sd8388607) y = 64'sd8388607;
        if (y < -64'sd8388608) y = -64'sd8388608;
        return y[23:0];
    endfunction

    function automatic logic signed [63:0] second_order(logic signed [63:0] tgt,
        logic signed [63:0] older, logic signed [63:0] newer, logic [63:0] c2, logic [63:0] c1);
        logic signed [129:0] s;
        s = scale_mul(tgt - older, c2, 32);
        s = s - scale_mul(newer - older, c1, 32) + 2 * newer - older;
        return clamp56(s);
    endfunction

    task automatic advance_channel(input tick_t t);
        logic [63:0] tt, c1, c2b, c2m, r, n, tw;
        logic signed [63:0] cosv, sinv, swing, k1, k2, rate, dph, nb, nm;
        pair_t e;
        tt = (tstep * tstep) >> 32;
        c1 = kb * tstep;
        c2b = (kb * kb * tt) >> 2;
        c2m = (kb * km * tt) >> 2;
        cosv = sine_of(phase + QUARTER_TURN);
        sinv = sine_of(phase);
        swing = (cosv < 0) ? scale_mul(-m_old, -cosv, 30) : scale_mul(m_old, cosv, 30);
        e.drive = to_q16_8(b_old + swing);
        e.mirror = to_q16_8(b_old - swing);
        expected_pairs.push_back(e);
        r = t.ratio;
        if (r < 1024) r = 1024;
        k1 = (4 * (4096 + r) * (4096 + r)) / r;
        if (r * r >= 64'd16777216) k2 = (4 * (r * r - 64'd16777216)) / r;
        else
        begin
            n = 64'd16777216 - r * r;
            k2 = -$signed((4 * n) / r);
        end
        rate = k1 - ((k2 * sinv) >>> 30);
        tw = (tstep * t.omega) >> 32;
        dph = scale_mul($signed(tw) * rate, INV_TWO_PI, 32);
        nb = second_order(64'(t.bias_tgt) * 64'sd16777216, b_old, b_new, c2b, c1);
        nm = second_order(64'(t.amp_tgt) * 64'sd16777216, m_old, m_new, c2m, c1);
        b_old = b_new;
        b_new = nb;
        m_old = m_new;
        m_new = nm;
        phase = phase + dph[31:0];
    endtask

    initial
    begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    // tick driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_ch.valid <= 1'b0;
            tick_ch.bias_target <= '0;
            tick_ch.amplitude_target <= '0;
            tick_ch.angular_rate <= '0;
            tick_ch.swing_ratio <= '0;
        end
        else
        begin
            if (tick_ch.valid && tick_ch.ready)
            begin
                advance_channel(pending_ticks[0]);
                void'(pending_ticks.pop_front());
            end
            if (tick_ch.valid && !tick_ch.ready)
                tick_ch.valid <= 1'b1;
            else if (pending_ticks.size() > 0 && $urandom_range(99) >= send_idle_pct)
            begin
                tick_ch.valid <= 1'b1;
                tick_ch.bias_target <= pending_ticks[0].bias_tgt;
                tick_ch.amplitude_target <= pending_ticks[0].amp_tgt;
                tick_ch.angular_rate <= pending_ticks[0].omega;
                tick_ch.swing_ratio <= pending_ticks[0].ratio;
            end
            else
                tick_ch.valid <= 1'b0;
        end
    end

    // long hold-off so the block backs up and stalls its tick input
    int hold_left = 0;
    bit held = 0;
    always @(posedge clk)
    begin
        if (pressure_arm && !held)
        begin
            held <= 1'b1;
            hold_left <= 12000;
        end
        else if (hold_left > 0)
            hold_left <= hold_left - 1;
    end

    // result monitor
    always @(posedge clk or negedge rst_n)
    begin
        pair_t e;
        if (!rst_n)
            res_ch.ready <= 1'b0;
        else
        begin
            if (res_ch.valid && res_ch.ready)
            begin
                if (expected_pairs.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result transfer: drive %0d mirror %0d",
                                 res_ch.drive_value, res_ch.mirror_value);
                end
                else
                begin
                    e = expected_pairs.pop_front();
                    if (e.drive !== res_ch.drive_value || e.mirror !== res_ch.mirror_value)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display({"result mismatch: drive exp %0d got %0d, ",
                                      "mirror exp %0d got %0d"},
                                     e.drive, res_ch.drive_value, e.mirror,
                                     res_ch.mirror_value);
                    end
                end
            end
            if (hold_left > 0)
                res_ch.ready <= 1'b0;
            else
                res_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
        @(posedge clk);
        wr_en <= 1'b1;
        wr_index <= idx;
        wr_data <= val;
        case (idx)
            REG_BIAS_GAIN: kb = {56'd0, val[7:0]};
            REG_AMP_GAIN:  km = {56'd0, val[7:0]};
            REG_TIME_STEP: tstep = {32'd0, val};
            default: ;
        endcase
        @(posedge clk);
        wr_en <= 1'b0;
    endtask

    task automatic set_channel(input int g_b, input int g_m, input logic [31:0] ts);
        write_reg(REG_BIAS_GAIN, g_b);
        write_reg(REG_AMP_GAIN, g_m);
        write_reg(REG_TIME_STEP, ts);
        write_reg(REG_UNUSED, $urandom);
    endtask

    function automatic logic [23:0] edgy24();
        case ($urandom_range(9))
            0: return 24'h7FFFFF;
            1: return 24'h800000;
            2: return 24'h000000;
            3: return 24'hFFFFFF;
            4, 5: return 24'($urandom_range(2000)) - 24'd1000;
            default: return 24'($urandom);
        endcase
    endfunction

    function automatic tick_t random_tick();
        tick_t t;
        t.bias_tgt = edgy24();
        t.amp_tgt = edgy24();
        t.omega = ($urandom_range(3) == 0) ? edgy24() : 24'($urandom_range(2000000));
        case ($urandom_range(7))
            0: t.ratio = 16'($urandom_range(1023));
            1: t.ratio = RATIO_MIN;
            2: t.ratio = 16'hFFFF;
            3: t.ratio = 16'd4096;
            default: t.ratio = 16'($urandom);
        endcase
        return t;
    endfunction

    task automatic run_phase(input int count, input int idle, input int stall);
        send_idle_pct = idle;
        recv_stall_pct = stall;
        repeat (count) pending_ticks.push_back(random_tick());
        while (pending_ticks.size() > 0 || expected_pairs.size() > 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    initial
    begin
        tick_t d;
        rst_n = 1'b0;
        wr_en = 1'b0;
        wr_index = '0;
        wr_data = '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: field extremes and swing ratio corners at reset settings
        d = '{24'h7FFFFF, 24'h7FFFFF, 24'hFFFFFF, 16'hFFFF};
        pending_ticks.push_back(d);
        d = '{24'h800000, 24'h800000, 24'h000000, 16'h0000};
        pending_ticks.push_back(d);
        d = '{24'h000100, 24'h000A00, 24'h010000, 16'd1023};
        pending_ticks.push_back(d);
        d = '{24'hFFFF00, 24'h7FFFFF, 24'h123456, 16'd1024};
        pending_ticks.push_back(d);
        d = '{24'h000000, 24'h000000, 24'hFFFFFF, 16'd4096};
        pending_ticks.push_back(d);
        repeat (15) pending_ticks.push_back(random_tick());
        run_phase(0, 0, 0);

        set_channel(5, 5, 32'd4294967);
        run_phase(300, 0, 0);
        set_channel(255, 255, 32'hFFFFFFFF);
        run_phase(200, 56, 0);
        // zero gains and zero step: momentum kept, phase does not move
        set_channel(0, 0, 32'd0);
        run_phase(100, 0, 56);
        set_channel(1, 255, 32'd1);
        run_phase(150, 7, 7);
        set_channel(20, 3, $urandom);
        pressure_arm = 1;
        run_phase(300, 0, 0);
        set_channel(5, 5, 32'd17179868);
        run_phase(450, 20, 30);

        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end
endmodule
